@@ hdl/spct_pkg.sv @@
package spct_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_Z = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP = 3'd6;

   localparam logic signed [17:0] NORMAL_Z_RESET = 18'sh10000;
   localparam logic [16:0]        TIME_STEP_RESET = 17'd655;

   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [17:0] normal_x;
      logic signed [17:0] normal_y;
      logic signed [17:0] normal_z;
      logic [16:0]        time_step;
   } plane_cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] y;
      if (x > SAT_MAX) begin
         y = 32'sh7FFF_FFFF;
      end else if (x < SAT_MIN) begin
         y = 32'sh8000_0000;
      end else begin
         y = 32'(x);
      end
      return y;
   endfunction

endpackage

@@ hdl/spct_datapath.sv @@
module spct_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [31:0]        center [3],
   input  logic signed [31:0]        vel [3],
   input  logic signed [31:0]        grav [3],
   input  logic [30:0]               radius,
   input  spct_pkg::plane_cfg_type   cfg,
   output logic                      out_valid,
   output logic                      contact,
   output logic signed [31:0]        distance,
   output logic signed [31:0]        point [3],
   output logic signed [31:0]        speed
);
   import spct_pkg::*;

   localparam int GS_W  = 50 - FRAC_BITS;
   localparam int W_W   = ((GS_W > 32) ? GS_W : 32) + 1;
   localparam int PW_W  = W_W + 18;
   localparam int SW_W  = PW_W + 2;
   localparam logic signed [31:0] SLOW_LIM = 32'((2 ** FRAC_BITS + 99999) / 100000);
   localparam logic signed [33:0] GAP_LIM  = 34'((5 * (2 ** FRAC_BITS) + 999) / 1000);

   logic signed [17:0] n [3];
   logic signed [31:0] o [3];
   logic signed [17:0] dt_s;

   logic [5:0] vld_ff;

   // stage 1
   logic signed [32:0] d1_ff [3], d1_in [3];
   logic signed [49:0] gd1_ff [3], gd1_in [3];
   logic signed [31:0] c1_ff [3], v1_ff [3];
   logic [30:0]        r1_ff;
   // stage 2
   logic signed [50:0]    pd2_ff [3], pd2_in [3];
   logic signed [W_W-1:0] w2_ff [3], w2_in [3];
   logic signed [31:0]    c2_ff [3];
   logic [30:0]           r2_ff;
   // stage 3
   logic signed [52:0]     sum3;
   logic signed [31:0]     sd3_ff, sd3_in;
   logic signed [PW_W-1:0] pw3_ff [3], pw3_in [3];
   logic signed [31:0]     c3_ff [3];
   logic [30:0]            r3_ff;
   // stage 4
   logic signed [32:0]     sd_abs;
   logic signed [SW_W-1:0] sum4;
   logic signed [33:0]     gap4_ff, gap4_in;
   logic signed [31:0]     spd4_ff, spd4_in, sd4_ff;
   logic signed [31:0]     c4_ff [3];
   logic [30:0]            r4_ff;
   // stage 5
   logic signed [32:0] nspd;
   logic signed [37:0] gx10;
   logic signed [51:0] gn5_ff [3], gn5_in [3];
   logic signed [50:0] sdt5_ff, sdt5_in;
   logic               neg5_ff, neg5_in, slow5_ff, slow5_in, prox5_ff, prox5_in;
   logic signed [33:0] gap5_ff;
   logic signed [31:0] sd5_ff, spd5_ff;
   logic signed [31:0] c5_ff [3];
   // stage 6
   logic               apr;
   logic               contact_ff, contact_in;
   logic signed [31:0] point_ff [3], point_in [3];
   logic signed [31:0] dist_ff, speed_ff;

   always_comb begin
      n[0] = cfg.normal_x;
      n[1] = cfg.normal_y;
      n[2] = cfg.normal_z;
      o[0] = cfg.origin_x;
      o[1] = cfg.origin_y;
      o[2] = cfg.origin_z;
      dt_s = $signed({1'b0, cfg.time_step});
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i]  = 33'(center[i]) - 33'(o[i]);
         gd1_in[i] = grav[i] * dt_s;
         pd2_in[i] = d1_ff[i] * n[i];
         w2_in[i]  = W_W'(v1_ff[i]) + W_W'(gd1_ff[i] >>> FRAC_BITS);
         pw3_in[i] = w2_ff[i] * n[i];
         gn5_in[i] = gap4_ff * n[i];
         point_in[i] = sat32(64'(53'(c5_ff[i]) - 53'(gn5_ff[i] >>> (FRAC_BITS + 1))));
      end

      // signed distance
      sum3   = 53'(pd2_ff[0]) + 53'(pd2_ff[1]) + 53'(pd2_ff[2]);
      sd3_in = sat32(64'(sum3 >>> FRAC_BITS));

      // gap and normal speed
      sd_abs  = (sd3_ff < 0) ? -33'(sd3_ff) : 33'(sd3_ff);
      gap4_in = 34'(sd_abs) - $signed({3'b000, r3_ff});
      sum4    = SW_W'(pw3_ff[0]) + SW_W'(pw3_ff[1]) + SW_W'(pw3_ff[2]);
      spd4_in = sat32(64'(sum4 >>> FRAC_BITS));

      // decision terms
      nspd     = -33'(spd4_ff);
      sdt5_in  = nspd * dt_s;
      neg5_in  = spd4_ff < 0;
      slow5_in = (spd4_ff < SLOW_LIM) && (gap4_ff < GAP_LIM);
      gx10     = (38'(gap4_ff) <<< 3) + (38'(gap4_ff) <<< 1);
      prox5_in = gx10 < $signed({7'b0000000, r4_ff});

      apr        = 51'(gap5_ff) <= (sdt5_ff >>> FRAC_BITS);
      contact_in = neg5_ff ? apr : (slow5_ff | prox5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d1_ff[i]    <= d1_in[i];
         gd1_ff[i]   <= gd1_in[i];
         c1_ff[i]    <= center[i];
         v1_ff[i]    <= vel[i];
         pd2_ff[i]   <= pd2_in[i];
         w2_ff[i]    <= w2_in[i];
         c2_ff[i]    <= c1_ff[i];
         pw3_ff[i]   <= pw3_in[i];
         c3_ff[i]    <= c2_ff[i];
         c4_ff[i]    <= c3_ff[i];
         gn5_ff[i]   <= gn5_in[i];
         c5_ff[i]    <= c4_ff[i];
         point_ff[i] <= point_in[i];
      end
      r1_ff      <= radius;
      r2_ff      <= r1_ff;
      sd3_ff     <= sd3_in;
      r3_ff      <= r2_ff;
      gap4_ff    <= gap4_in;
      spd4_ff    <= spd4_in;
      sd4_ff     <= sd3_ff;
      r4_ff      <= r3_ff;
      sdt5_ff    <= sdt5_in;
      neg5_ff    <= neg5_in;
      slow5_ff   <= slow5_in;
      prox5_ff   <= prox5_in;
      gap5_ff    <= gap4_ff;
      sd5_ff     <= sd4_ff;
      spd5_ff    <= spd4_ff;
      contact_ff <= contact_in;
      dist_ff    <= sd5_ff;
      speed_ff   <= spd5_ff;
   end

   assign out_valid = vld_ff[5];
   assign contact   = contact_ff;
   assign distance  = dist_ff;
   assign point     = point_ff;
   assign speed     = speed_ff;

endmodule

@@ hdl/sphere_plane_contact_test_core.sv @@
// sphere-plane contact test, six register stages
// rsp_valid rises together with the result, carried down a valid chain beside the data
// throughput: one transaction per cycle, busy is always low
// the multiplier stages (g*dt, d*n, w*n, gap*n and spd*dt) set the depth; the receiver cannot stall
// synchronous active-high reset clears the valid chain and restores the plane registers
module sphere_plane_contact_test_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic signed [31:0] req_grav_x,
   input  logic signed [31:0] req_grav_y,
   input  logic signed [31:0] req_grav_z,
   input  logic [30:0]        req_radius,
   input  logic               csr_we,
   input  logic [spct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic               rsp_valid,
   output logic               rsp_contact,
   output logic signed [31:0] rsp_signed_distance,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic signed [31:0] rsp_normal_speed
);
   import spct_pkg::*;

   plane_cfg_type      cfg_ff, cfg_in;
   logic               accept;
   logic signed [31:0] center [3];
   logic signed [31:0] vel [3];
   logic signed [31:0] grav [3];
   logic signed [31:0] point [3];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:  cfg_in.origin_x  = $signed(csr_wdata);
            CSR_ORIGIN_Y:  cfg_in.origin_y  = $signed(csr_wdata);
            CSR_ORIGIN_Z:  cfg_in.origin_z  = $signed(csr_wdata);
            CSR_NORMAL_X:  cfg_in.normal_x  = $signed(csr_wdata[17:0]);
            CSR_NORMAL_Y:  cfg_in.normal_y  = $signed(csr_wdata[17:0]);
            CSR_NORMAL_Z:  cfg_in.normal_z  = $signed(csr_wdata[17:0]);
            CSR_TIME_STEP: cfg_in.time_step = csr_wdata[16:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x  <= '0;
         cfg_ff.origin_y  <= '0;
         cfg_ff.origin_z  <= '0;
         cfg_ff.normal_x  <= '0;
         cfg_ff.normal_y  <= '0;
         cfg_ff.normal_z  <= NORMAL_Z_RESET;
         cfg_ff.time_step <= TIME_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign center[0] = req_center_x;
   assign center[1] = req_center_y;
   assign center[2] = req_center_z;
   assign vel[0]    = req_vel_x;
   assign vel[1]    = req_vel_y;
   assign vel[2]    = req_vel_z;
   assign grav[0]   = req_grav_x;
   assign grav[1]   = req_grav_y;
   assign grav[2]   = req_grav_z;

   spct_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .center    (center),
      .vel       (vel),
      .grav      (grav),
      .radius    (req_radius),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .contact   (rsp_contact),
      .distance  (rsp_signed_distance),
      .point     (point),
      .speed     (rsp_normal_speed)
   );

   assign rsp_point_x = point[0];
   assign rsp_point_y = point[1];
   assign rsp_point_z = point[2];

endmodule

@@ bench/sphere_plane_contact_test_core_tb.sv @@
module sphere_plane_contact_test_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spct_pkg::*;

   localparam int FRAC = 16;
   localparam int PIPE_DEPTH = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 60;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint REST_SPEED_LIM = (ONE + 99999) / 100000;
   localparam longint REST_GAP_LIM = (ONE * 5 + 999) / 1000;
   localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] grav_x;
      logic signed [31:0] grav_y;
      logic signed [31:0] grav_z;
      logic [30:0]        radius;
   } sphere_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] distance;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] speed;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic rsp_valid;
   logic rsp_contact;
   logic signed [31:0] rsp_signed_distance;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic signed [31:0] rsp_point_z;
   logic signed [31:0] rsp_normal_speed;

   sphere_type cur_sphere = '0;
   sphere_type pending_spheres[$];
   contact_type expected_contacts[$];
   plane_cfg_type plane_model = '{default: '0, normal_z: NORMAL_Z_RESET,
                                  time_step: TIME_STEP_RESET};
   logic taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int pushed_count = 0;
   int accepted_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   sphere_plane_contact_test_core u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_center_x       (cur_sphere.center_x),
      .req_center_y       (cur_sphere.center_y),
      .req_center_z       (cur_sphere.center_z),
      .req_vel_x          (cur_sphere.vel_x),
      .req_vel_y          (cur_sphere.vel_y),
      .req_vel_z          (cur_sphere.vel_z),
      .req_grav_x         (cur_sphere.grav_x),
      .req_grav_y         (cur_sphere.grav_y),
      .req_grav_z         (cur_sphere.grav_z),
      .req_radius         (cur_sphere.radius),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_contact        (rsp_contact),
      .rsp_signed_distance(rsp_signed_distance),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_point_z        (rsp_point_z),
      .rsp_normal_speed   (rsp_normal_speed)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_q32(input longint x);
      if (x > Q_MAX) return Q_MAX;
      if (x < Q_MIN) return Q_MIN;
      return x;
   endfunction

   function automatic contact_type predict_contact(input sphere_type s, input plane_cfg_type pc);
      longint c[3], v[3], g[3], n[3], o[3];
      longint r, dt, acc, sd, gap, spd, w;
      contact_type res;
      c[0] = longint'(s.center_x);
      c[1] = longint'(s.center_y);
      c[2] = longint'(s.center_z);
      v[0] = longint'(s.vel_x);
      v[1] = longint'(s.vel_y);
      v[2] = longint'(s.vel_z);
      g[0] = longint'(s.grav_x);
      g[1] = longint'(s.grav_y);
      g[2] = longint'(s.grav_z);
      n[0] = longint'(pc.normal_x);
      n[1] = longint'(pc.normal_y);
      n[2] = longint'(pc.normal_z);
      o[0] = longint'(pc.origin_x);
      o[1] = longint'(pc.origin_y);
      o[2] = longint'(pc.origin_z);
      r = longint'(s.radius);
      dt = longint'(pc.time_step);

      acc = 0;
      for (int i = 0; i < 3; i++) acc += (c[i] - o[i]) * n[i];
      sd = clamp_q32(acc >>> FRAC);
      gap = (sd < 0 ? -sd : sd) - r;

      res.distance = sd[31:0];
      res.point_x = 32'(clamp_q32(c[0] - ((gap * n[0]) >>> (FRAC + 1))));
      res.point_y = 32'(clamp_q32(c[1] - ((gap * n[1]) >>> (FRAC + 1))));
      res.point_z = 32'(clamp_q32(c[2] - ((gap * n[2]) >>> (FRAC + 1))));

      acc = 0;
      for (int i = 0; i < 3; i++) begin
         w = v[i] + ((g[i] * dt) >>> FRAC);
         acc += w * n[i];
      end
      spd = clamp_q32(acc >>> FRAC);
      res.speed = spd[31:0];

      // approaching spheres get no fallback test
      if (spd < 0) begin
         res.hit = gap <= ((-spd * dt) >>> FRAC);
      end else if (spd < REST_SPEED_LIM && gap < REST_GAP_LIM) begin
         res.hit = 1'b1;
      end else begin
         res.hit = gap * 10 < r;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input longint seen, input longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, seen, want, $realtime);
      error_count++;
   endtask

   task automatic check_contact(input contact_type want);
      if (rsp_contact !== want.hit)
         report_mismatch("contact", rsp_contact, want.hit);
      if (rsp_signed_distance !== want.distance)
         report_mismatch("signed_distance", rsp_signed_distance, want.distance);
      if (rsp_point_x !== want.point_x)
         report_mismatch("point_x", rsp_point_x, want.point_x);
      if (rsp_point_y !== want.point_y)
         report_mismatch("point_y", rsp_point_y, want.point_y);
      if (rsp_point_z !== want.point_z)
         report_mismatch("point_z", rsp_point_z, want.point_z);
      if (rsp_normal_speed !== want.speed)
         report_mismatch("normal_speed", rsp_normal_speed, want.speed);
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_contacts.size() == 0) begin
               report_mismatch("result with no transaction pending", 1, 0);
            end else begin
               check_contact(expected_contacts.pop_front());
            end
         end
         if (start && !busy) begin
            expected_contacts.insert(expected_contacts.size(),
                                     predict_contact(cur_sphere, plane_model));
            accepted_count++;
         end
      end
      taken <= !reset && start && !busy;
   end

   // driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_spheres.size() > 0) begin
            cur_sphere <= pending_spheres.pop_front();
            start <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int jitter(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic sphere_type axial(input int cz, input int vz, input int gz, input int r);
      sphere_type s;
      s = '0;
      s.center_x = $urandom;
      s.center_y = $urandom;
      s.center_z = cz;
      s.vel_x = $urandom;
      s.vel_y = $urandom;
      s.vel_z = vz;
      s.grav_x = $urandom;
      s.grav_y = $urandom;
      s.grav_z = gz;
      s.radius = 31'(r);
      return s;
   endfunction

   task automatic push_sphere(input sphere_type s);
      pending_spheres.insert(pending_spheres.size(), s);
      pushed_count++;
   endtask

   task automatic add_random(input int count);
      sphere_type s;
      contact_type probe;
      longint mag;
      int mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 3);
         if (mode == 0) begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
         end else begin
            // sphere near the plane, radius set so the gap lands near zero
            s.center_x = plane_model.origin_x + jitter(1 << 18);
            s.center_y = plane_model.origin_y + jitter(1 << 18);
            s.center_z = plane_model.origin_z + jitter(1 << 18);
            if (mode == 1) begin
               s.vel_x = 0;
               s.vel_y = 0;
               s.vel_z = 0;
               s.grav_x = 0;
               s.grav_y = 0;
               s.grav_z = 0;
            end else begin
               s.vel_x = jitter(1 << 20);
               s.vel_y = jitter(1 << 20);
               s.vel_z = jitter(1 << 20);
               s.grav_x = jitter(1 << 21);
               s.grav_y = jitter(1 << 21);
               s.grav_z = jitter(1 << 21);
            end
            s.radius = '0;
            probe = predict_contact(s, plane_model);
            mag = longint'(probe.distance);
            if (mag < 0) mag = -mag;
            mag = mag - jitter(($urandom_range(0, 1) == 0) ? 600 : 20000);
            if (mag < 0) mag = 0;
            if (mag > Q_MAX) mag = Q_MAX;
            s.radius = mag[30:0];
         end
         push_sphere(s);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ORIGIN_X:  plane_model.origin_x = data;
         CSR_ORIGIN_Y:  plane_model.origin_y = data;
         CSR_ORIGIN_Z:  plane_model.origin_z = data;
         CSR_NORMAL_X:  plane_model.normal_x = data[17:0];
         CSR_NORMAL_Y:  plane_model.normal_y = data[17:0];
         CSR_NORMAL_Z:  plane_model.normal_z = data[17:0];
         CSR_TIME_STEP: plane_model.time_step = data[16:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_plane(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] oz, input logic [31:0] nx,
                                input logic [31:0] ny, input logic [31:0] nz,
                                input logic [31:0] dt);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      write_csr(CSR_NORMAL_X, nx);
      write_csr(CSR_NORMAL_Y, ny);
      write_csr(CSR_NORMAL_Z, nz);
      write_csr(CSR_TIME_STEP, dt);
      csr_we <= 1'b0;
   endtask

   // wait until every accepted transaction has its result, then let the pipe empty
   task automatic drain();
      while (accepted_count != pushed_count || expected_contacts.size() != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   function automatic logic [31:0] any_normal();
      return $urandom_range(0, 131072) - 65536;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed transactions on the reset plane: z up through the origin, dt 655
      push_sphere('0);
      push_sphere({{9{32'h7FFF_FFFF}}, 31'h7FFF_FFFF});
      push_sphere({{9{32'h8000_0000}}, 31'h0});
      push_sphere({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 31'h7FFF_FFFF});
      push_sphere(axial(200, 0, 0, 0));
      push_sphere(axial(327, 0, 0, 0));
      push_sphere(axial(328, 0, 0, 0));
      push_sphere(axial(21 << 16, 0, 0, 20 << 16));
      push_sphere(axial(11 << 16, 0, 0, 10 << 16));
      push_sphere(axial(655, -65536, 0, 0));
      push_sphere(axial(656, -65536, 0, 0));
      push_sphere(axial((100 << 16) + 1, -1, 0, 100 << 16));
      push_sphere(axial((10 << 16) + 100, 1 << 16, 0, 10 << 16));
      push_sphere(axial(-(5 << 16), 0, 0, 4 << 16));
      push_sphere(axial(1 << 16, 0, 0, 3 << 16));
      push_sphere(axial(50, 0, -642908, 0));
      push_sphere(axial(100, 0, -642908, 0));
      push_sphere(axial(200, 1, 0, 0));
      push_sphere(axial(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      push_sphere(axial(0, 32'h8000_0000, 32'h8000_0000, 0));
      add_random(RANDOM_PER_PHASE);
      drain();

      write_csr(CSR_UNMAPPED, $urandom);
      program_plane($urandom, $urandom, $urandom, any_normal(), any_normal(),
                    any_normal(), $urandom_range(1, 65536));
      add_random(RANDOM_PER_PHASE);
      drain();

      program_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    65536, -65536, 65536, 65536);
      add_random(RANDOM_PER_PHASE);
      drain();

      program_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    -65536, 65536, -65536, 1);
      add_random(RANDOM_PER_PHASE);
      drain();

      // garbage above the register widths and out-of-range normals
      program_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      add_random(RANDOM_PER_PHASE);
      drain();

      program_plane(jitter(1 << 20), jitter(1 << 20), jitter(1 << 20),
                    46341, 46341, 0, 0);
      add_random(RANDOM_PER_PHASE);
      drain();

      program_plane(0, 0, 0, -131072, 131071, -131072, 65535);
      add_random(RANDOM_PER_PHASE);
      drain();

      program_plane(0, 0, 0, 0, 0, 65536, 655);
      add_random(RANDOM_PER_PHASE);
      drain();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
